>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/pncrq_pkg.sv
// Package with types, codes and defaults of the command retry queue.
`default_nettype none
package pncrq_pkg;
  localparam int NUM_NODES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int ENTRY_W = 60;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_FAIL = 2'd3;

  localparam logic [3:0] K_TX      = 4'd0;
  localparam logic [3:0] K_QUEUED  = 4'd1;
  localparam logic [3:0] K_RANGE   = 4'd2;
  localparam logic [3:0] K_NONODE  = 4'd3;
  localparam logic [3:0] K_DROPPED = 4'd4;
  localparam logic [3:0] K_GAVEUP  = 4'd5;
  localparam logic [3:0] K_ACKED   = 4'd6;
  localparam logic [3:0] K_STALE   = 4'd7;
  localparam logic [3:0] K_SENDERR = 4'd8;

  localparam logic [2:0] CFG_FIRST_POLE = 3'd0;
  localparam logic [2:0] CFG_MASK       = 3'd1;
  localparam logic [2:0] CFG_MAX_ATT    = 3'd2;
  localparam logic [2:0] CFG_ACK_TO     = 3'd3;
  localparam logic [2:0] CFG_FAST       = 3'd4;

  localparam logic [7:0]  RST_FIRST_POLE = 8'd9;
  localparam logic [7:0]  RST_MASK       = 8'hFF;
  localparam logic [3:0]  RST_MAX_ATT    = 4'd4;
  localparam logic [15:0] RST_ACK_TO     = 16'd1500;
  localparam logic [15:0] RST_FAST       = 16'd150;

  typedef struct packed {
    logic [7:0]  action;
    logic [15:0] seq;
    logic [3:0]  attempts;
    logic [31:0] sent;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch_in;     // capture input beat
    logic node_first;   // tick walk: node 0
    logic node_next;    // tick walk: advance node
    logic rd_head;      // read head entry
    logic pop;          // pop head of current node
    logic push;         // write new entry at tail
    logic wr_head;      // write back modified head
    logic emit;         // load result register
    logic [3:0] kind;
    logic use_entry;    // result fields come from entry
    logic emit_last;
    logic stage;        // capture tick result in the stage register
    logic from_stage;   // result register loads from the stage register
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] opcode;
    logic in_range;
    logic present;
    logic nonempty;
    logic full;
    logic seq_match;
    logic waiting;      // sent and timeout not expired
    logic give_up;
    logic node_last;
    logic staged;       // stage register holds a tick result
    logic out_free;
  } dp_stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/per_node_command_retry_queue.sv
// Top level of the per-node command retry queue.
// Usage: items arrive on in_* (valid/ready); a beat carries an opcode: enqueue,
// acknowledgement, time tick or send failure. Results leave on out_* as beats,
// zero to several per item; out_last marks the final beat of an item.
// Configuration writes enter on cfg_* (valid/ready, always ready) by register index.
// The block works on one item at a time: in_ready is high only when idle.
// An ack, an out-of-window or absent-node enqueue, or an ignored send failure
// passes the decode, read and evaluate states; an enqueue also the emit state and
// a noted send failure the wait state; a full-queue enqueue that drops its oldest
// entry also stays in the emit state to push. A tick walks every node queue in
// turn through the one entry memory: each node passes the read and evaluate
// states, a transmitted entry also the wait state, and the walk ends in flush.
// Each tick result waits in a stage register until the next one is found, so
// the final beat of a tick leaves at the end of the walk with out_last set.
// One result register sits at the output; when the receiver stalls the
// controller holds its state until the register frees, nothing is lost.
// Reset clears queue pointers, sets the sequence counter to one and loads
// register defaults; entry memory needs no clearing because only written
// entries are ever used.
`default_nettype none
module per_node_command_retry_queue import pncrq_pkg::*; #(
  parameter int NUM_NODES = NUM_NODES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_pole_id,
  input  wire logic [2:0]  in_node_index,
  input  wire logic [7:0]  in_action_code,
  input  wire logic [15:0] in_ack_seq,
  input  wire logic        in_ack_refused,
  input  wire logic [31:0] in_now_ms,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [3:0]  out_kind,
  output      logic [7:0]  out_out_pole,
  output      logic [7:0]  out_out_action,
  output      logic [15:0] out_out_seq,
  output      logic [3:0]  out_out_attempts,
  output      logic        out_out_refused,
  output      logic        out_last
);
  ctl_cmd_t cmd;
  dp_stat_t st;

  assign cfg_ready = 1'b1;

  pncrq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .st(st), .cmd(cmd)
  );

  pncrq_dp #(.NUM_NODES(NUM_NODES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_opcode(in_opcode), .in_pole_id(in_pole_id), .in_node_index(in_node_index),
    .in_action_code(in_action_code), .in_ack_seq(in_ack_seq),
    .in_ack_refused(in_ack_refused), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_out_pole(out_out_pole), .out_out_action(out_out_action),
    .out_out_seq(out_out_seq), .out_out_attempts(out_out_attempts),
    .out_out_refused(out_out_refused), .out_last(out_last)
  );
endmodule
`default_nettype wire

>>> hw/rtl/pncrq_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module pncrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/pncrq_ctrl.sv
// Controller state machine of the command retry queue.
`default_nettype none
module pncrq_ctrl import pncrq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire dp_stat_t st,
  output      ctl_cmd_t cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DEC   = 8'b00000010,
    S_RD    = 8'b00000100,
    S_EVAL  = 8'b00001000,
    S_EMIT2 = 8'b00010000,
    S_WAIT  = 8'b00100000,
    S_NEXT  = 8'b01000000,
    S_FLUSH = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  // The new entry of an enqueue on a full queue still has to be pushed.
  logic pend_r, pend_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.node_first = (st.opcode == OP_TICK);
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (st.out_free) begin
          case (st.opcode)
            OP_ENQ: begin
              if (!st.in_range) begin
                cmd.emit = 1'b1; cmd.kind = K_RANGE; cmd.emit_last = 1'b1;
                state_nxt = S_IDLE;
              end else if (!st.present) begin
                cmd.emit = 1'b1; cmd.kind = K_NONODE; cmd.emit_last = 1'b1;
                state_nxt = S_IDLE;
              end else if (st.full) begin
                cmd.emit = 1'b1; cmd.kind = K_DROPPED; cmd.use_entry = 1'b1;
                cmd.pop = 1'b1;
                pend_nxt = 1'b1;
                state_nxt = S_EMIT2;
              end else begin
                cmd.push = 1'b1;
                state_nxt = S_EMIT2;
              end
            end
            OP_ACK: begin
              cmd.emit = 1'b1; cmd.emit_last = 1'b1;
              if (!st.present) begin
                cmd.kind = K_NONODE;
              end else if (st.nonempty && st.seq_match) begin
                cmd.kind = K_ACKED; cmd.use_entry = 1'b1; cmd.pop = 1'b1;
              end else begin
                cmd.kind = K_STALE;
              end
              state_nxt = S_IDLE;
            end
            OP_FAIL: begin
              if (st.present && st.nonempty) begin
                cmd.wr_head = 1'b1;
                state_nxt = S_WAIT;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            default: begin
              // Tick: one node per visit. A result goes to the stage register and
              // pushes the one staged before it out as a non-final beat.
              if (!st.nonempty || st.waiting) begin
                state_nxt = st.node_last ? S_FLUSH : S_NEXT;
              end else if (st.give_up) begin
                cmd.stage = 1'b1; cmd.kind = K_GAVEUP; cmd.use_entry = 1'b1;
                cmd.pop = 1'b1;
                if (st.staged) begin
                  cmd.emit = 1'b1; cmd.from_stage = 1'b1;
                end
                state_nxt = st.node_last ? S_FLUSH : S_NEXT;
              end else begin
                cmd.wr_head = 1'b1;
                state_nxt = S_WAIT;
              end
            end
          endcase
        end
      end
      S_EMIT2: begin
        // After a dropped head the new entry is pushed first, then reported.
        if (pend_r) begin
          cmd.push = 1'b1;
          pend_nxt = 1'b0;
        end else if (st.out_free) begin
          cmd.emit = 1'b1; cmd.kind = K_QUEUED; cmd.use_entry = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: begin
        if (st.out_free) begin
          if (st.opcode == OP_FAIL) begin
            cmd.emit = 1'b1; cmd.use_entry = 1'b1;
            cmd.kind = K_SENDERR; cmd.emit_last = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.stage = 1'b1; cmd.kind = K_TX; cmd.use_entry = 1'b1;
            if (st.staged) begin
              cmd.emit = 1'b1; cmd.from_stage = 1'b1;
            end
            state_nxt = st.node_last ? S_FLUSH : S_NEXT;
          end
        end
      end
      S_NEXT: begin
        cmd.node_next = 1'b1;
        state_nxt = S_RD;
      end
      S_FLUSH: begin
        // End of a tick walk: the staged result is the final beat.
        if (!st.staged) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit = 1'b1; cmd.from_stage = 1'b1; cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/pncrq_dp.sv
// Datapath of the command retry queue: registers, queue pointers and entry RAM.
`default_nettype none
module pncrq_dp import pncrq_pkg::*; #(
  parameter int NUM_NODES = NUM_NODES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_cmd_t    cmd,
  output      dp_stat_t    st,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_pole_id,
  input  wire logic [2:0]  in_node_index,
  input  wire logic [7:0]  in_action_code,
  input  wire logic [15:0] in_ack_seq,
  input  wire logic        in_ack_refused,
  input  wire logic [31:0] in_now_ms,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [3:0]  out_kind,
  output      logic [7:0]  out_out_pole,
  output      logic [7:0]  out_out_action,
  output      logic [15:0] out_out_seq,
  output      logic [3:0]  out_out_attempts,
  output      logic        out_out_refused,
  output      logic        out_last
);
  localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = NUM_NODES * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);

  // Configuration.
  logic [7:0]  first_pole_r;
  logic [7:0]  mask_r;
  logic [3:0]  max_att_r;
  logic [15:0] ack_to_r;
  logic [15:0] fast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pole_r <= RST_FIRST_POLE;
      mask_r       <= RST_MASK;
      max_att_r    <= RST_MAX_ATT;
      ack_to_r     <= RST_ACK_TO;
      fast_r       <= RST_FAST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_POLE: first_pole_r <= cfg_data[7:0];
        CFG_MASK:       mask_r       <= cfg_data[7:0];
        CFG_MAX_ATT:    max_att_r    <= cfg_data[3:0];
        CFG_ACK_TO:     ack_to_r     <= cfg_data;
        CFG_FAST:       fast_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured input beat.
  logic [1:0]  op_r;
  logic [7:0]  pole_r;
  logic [2:0]  node_in_r;
  logic [7:0]  act_r;
  logic [15:0] aseq_r;
  logic        ref_r;
  logic [31:0] now_r;
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= in_opcode; pole_r <= in_pole_id; node_in_r <= in_node_index;
      act_r <= in_action_code; aseq_r <= in_ack_seq; ref_r <= in_ack_refused;
      now_r <= in_now_ms;
    end
  end

  // Node selection and window check.
  logic [7:0] pdiff;
  logic       in_range;
  logic [NW:0] enq_node;
  assign pdiff    = pole_r - first_pole_r;
  assign in_range = (pole_r >= first_pole_r) && ({24'd0, pdiff} < NUM_NODES);
  assign enq_node = (NW + 1)'(pdiff);

  logic [NW-1:0] node_r, node_nxt;
  logic [NW-1:0] cur;
  always_comb begin
    node_nxt = node_r;
    if (cmd.latch_in) begin
      node_nxt = '0;
    end else if (cmd.node_first) begin
      node_nxt = '0;
    end else if (cmd.node_next) begin
      node_nxt = node_r + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  logic [7:0] sel_node;
  always_comb begin
    if (op_r == OP_TICK) begin
      sel_node = 8'(node_r);
    end else if (op_r == OP_ENQ) begin
      sel_node = 8'(enq_node);
    end else begin
      sel_node = {5'd0, node_in_r};
    end
  end
  assign cur = sel_node[NW-1:0];
  logic present;
  assign present = (sel_node < 8) && ({24'd0, sel_node} < NUM_NODES) && mask_r[sel_node[2:0]];

  // Queue pointers.
  logic [QW-1:0] head_r [NUM_NODES];
  logic [CW-1:0] cnt_r  [NUM_NODES];
  logic [15:0]   nseq_r;

  logic [CW-1:0] cnt_cur;
  logic [QW-1:0] head_cur;
  assign cnt_cur  = cnt_r[cur];
  assign head_cur = head_r[cur];

  // Tail slot: head plus count, wrapped by one compare and subtract.
  logic [QW-1:0] tail;
  logic [CW:0]   tsum;
  assign tsum = (CW+1)'(head_cur) + (CW+1)'(cnt_cur);
  assign tail = (tsum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(tsum - (CW+1)'(QUEUE_DEPTH))
                                               : QW'(tsum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_NODES; k++) begin
        head_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
      nseq_r <= 16'd1;
    end else if (cmd.pop) begin
      head_r[cur] <= (head_cur == QW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
      cnt_r[cur]  <= cnt_cur - 1'b1;
    end else if (cmd.push && !(cnt_cur == CW'(QUEUE_DEPTH))) begin
      cnt_r[cur] <= cnt_cur + 1'b1;
      nseq_r     <= (nseq_r == 16'hFFFF) ? 16'd1 : nseq_r + 1'b1;
    end
  end

  // Entry RAM. A written entry is kept in a shadow so its result needs no read.
  entry_t rd_e, wr_e, shadow_r;
  logic   we;
  logic [AW-1:0] waddr, raddr;
  logic [AW-1:0] base;
  assign base  = AW'(cur) * AW'(QUEUE_DEPTH);
  assign raddr = base + AW'(head_cur);

  logic [15:0] back;
  assign back = (fast_r >= ack_to_r) ? 16'd0 : ack_to_r - fast_r;

  always_comb begin
    wr_e  = rd_e;
    waddr = raddr;
    we    = 1'b0;
    if (cmd.push && !(cnt_cur == CW'(QUEUE_DEPTH))) begin
      we = 1'b1;
      waddr = base + AW'(tail);
      wr_e.action = act_r; wr_e.seq = nseq_r; wr_e.attempts = '0; wr_e.sent = '0;
    end else if (cmd.wr_head) begin
      we = 1'b1;
      if (op_r == OP_FAIL) begin
        wr_e.sent = now_r - {16'd0, back};
      end else begin
        wr_e.attempts = rd_e.attempts + 1'b1;
        wr_e.sent = now_r;
      end
    end
  end

  logic [ENTRY_W-1:0] rdata;
  pncrq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_e),
    .raddr(raddr), .rdata(rdata)
  );

  entry_t ram_e;
  assign ram_e = entry_t'(rdata);
  // rd_head held in a register so later writes see the fresh read value.
  entry_t hold_r;
  logic   rdv_r;
  always_ff @(posedge clk) begin
    rdv_r <= cmd.rd_head;
    if (rdv_r) begin
      hold_r <= ram_e;
    end
    if (we) begin
      shadow_r <= wr_e;
    end
  end
  assign rd_e = rdv_r ? ram_e : hold_r;

  logic [31:0] elapsed;
  assign elapsed = now_r - rd_e.sent;

  // Stage register for tick results: a beat leaves only once it is known
  // whether another result of the same tick follows.
  logic        stg_valid_r;
  logic [3:0]  stg_kind_r;
  logic [7:0]  stg_pole_r;
  logic [7:0]  stg_action_r;
  logic [15:0] stg_seq_r;
  logic [3:0]  stg_att_r;

  assign st.opcode     = op_r;
  assign st.in_range   = in_range;
  assign st.present    = present;
  assign st.nonempty   = (cnt_cur != '0);
  assign st.full       = (cnt_cur == CW'(QUEUE_DEPTH));
  assign st.seq_match  = (rd_e.seq == aseq_r);
  assign st.waiting    = (rd_e.attempts != '0) && (elapsed < {16'd0, ack_to_r});
  assign st.give_up    = (rd_e.attempts >= max_att_r);
  assign st.node_last  = (int'(node_r) == NUM_NODES - 1);
  assign st.staged     = stg_valid_r;
  assign st.out_free   = !out_valid || out_ready;

  // Result fields of the current command.
  logic [7:0] pole_of;
  assign pole_of = first_pole_r + sel_node;
  entry_t src;
  assign src = (cmd.kind == K_QUEUED || cmd.kind == K_TX || cmd.kind == K_SENDERR)
               ? shadow_r : rd_e;

  logic [7:0]  res_pole;
  logic [7:0]  res_action;
  logic [15:0] res_seq;
  logic [3:0]  res_att;
  always_comb begin
    res_pole = (cmd.kind == K_RANGE || cmd.kind == K_NONODE) && op_r == OP_ENQ
               ? pole_r : pole_of;
    if (cmd.use_entry) begin
      res_action = src.action; res_seq = src.seq; res_att = src.attempts;
    end else begin
      res_action = '0; res_att = '0;
      res_seq = (cmd.kind == K_STALE) ? aseq_r : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (cmd.stage) begin
      stg_valid_r <= 1'b1;
    end else if (cmd.emit && cmd.from_stage) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage) begin
      stg_kind_r <= cmd.kind; stg_pole_r <= res_pole; stg_action_r <= res_action;
      stg_seq_r <= res_seq; stg_att_r <= res_att;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      if (cmd.from_stage) begin
        out_kind <= stg_kind_r; out_out_pole <= stg_pole_r;
        out_out_action <= stg_action_r; out_out_seq <= stg_seq_r;
        out_out_attempts <= stg_att_r; out_out_refused <= 1'b0;
      end else begin
        out_kind <= cmd.kind; out_out_pole <= res_pole;
        out_out_action <= res_action; out_out_seq <= res_seq;
        out_out_attempts <= res_att;
        out_out_refused <= (cmd.kind == K_ACKED) ? ref_r : 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/pncrq_checker.sv
// Port-level checker of the command retry queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pncrq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_kind,
  input wire logic       out_last
);
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
    "input accepted while a previous item is still in work")
  `CHK_IMPLY(a_kind_legal, clk, rst_n, out_valid, out_kind <= 4'd8,
    "result kind out of range")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
    "result beat withdrawn before it was taken")
  `CHK_IMPLY(a_no_out_idle_item, clk, rst_n, out_valid && !out_last,
    !in_ready, "non-final result while the block reports idle")
endmodule
bind per_node_command_retry_queue pncrq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
  .out_last(out_last)
);
`default_nettype wire
